@@ rtl/omed_pkg.sv @@
// Shared types and constants for the orientation and motion event detector.
// Used by every module of the block; depends on nothing.
package omed_pkg;

  // Accelerometer sample width (1 g = 1024 LSB).
  localparam int SAMPLE_WIDTH = 16;
  // Sum of three squares stays below 2^(2*SAMPLE_WIDTH).
  localparam int MAG_W = 2 * SAMPLE_WIDTH;
  // Width of the deviation compare against the 32 bit registers.
  localparam int DEV_W = (MAG_W > 32) ? MAG_W : 32;

  // Stream widths, rounded up to whole bytes.
  localparam int IN_W  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((3 + 3 * SAMPLE_WIDTH + 7) / 8) * 8;

  // Event queue depth and its count width (count must hold the depth itself).
  localparam int EVQ_DEPTH = 8;
  localparam int EVQ_AW    = $clog2(EVQ_DEPTH);
  localparam int EVQ_CW    = EVQ_AW + 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [2:0] axis_t;

  // Axis codes: 2*axis + (sign is non-negative).
  localparam axis_t AXIS_UNKNOWN = 3'd6;

  typedef enum logic [1:0] {
    EV_MOVED   = 2'd0,
    EV_CHANGED = 2'd1,
    EV_STOPPED = 2'd2
  } ev_kind_t;

  typedef enum logic [2:0] {
    CFG_GRAVITY_SQ   = 3'd0,
    CFG_MOVING_TOL   = 3'd1,
    CFG_CHECK_PERIOD = 3'd2,
    CFG_STABLE_TICKS = 3'd3,
    CFG_STOP_DELAY   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] gravity_sq;
    logic [31:0] moving_tolerance;
    logic [7:0]  check_period;
    logic [15:0] stable_ticks;
    logic [15:0] stop_delay_ticks;
  } cfg_t;

  // One measured sample after the squaring stages.
  typedef struct packed {
    sample_t          x;
    sample_t          y;
    sample_t          z;
    axis_t            axis;
    logic [MAG_W-1:0] mag;
  } meas_t;

  // One result item.
  typedef struct packed {
    ev_kind_t kind;
    axis_t    axis;
    sample_t  x;
    sample_t  y;
    sample_t  z;
    logic     last;
  } evt_t;

endpackage

@@ rtl/omed_square.sv @@
// Magnitude stages: absolute values, up axis pick, squares, then their sum.
// Depends on omed_pkg.
module omed_square (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  omed_pkg::sample_t in_x,
  input  omed_pkg::sample_t in_y,
  input  omed_pkg::sample_t in_z,
  output logic [1:0]       stage_valid,
  output logic             meas_valid,
  output omed_pkg::meas_t  meas
);
  import omed_pkg::*;

  logic [SAMPLE_WIDTH-1:0] ax, ay, az;
  logic [1:0]              best;
  logic                    best_neg;
  axis_t                   cur_axis;

  // stage 2 registers
  logic                    sq_valid;
  logic [MAG_W-1:0]        sq_x, sq_y, sq_z;
  sample_t                 s2_x, s2_y, s2_z;
  axis_t                   s2_axis;

  // magnitudes; the most negative value maps to its positive twin
  assign ax = in_x[SAMPLE_WIDTH-1] ? (~$unsigned(in_x) + 1'b1) : $unsigned(in_x);
  assign ay = in_y[SAMPLE_WIDTH-1] ? (~$unsigned(in_y) + 1'b1) : $unsigned(in_y);
  assign az = in_z[SAMPLE_WIDTH-1] ? (~$unsigned(in_z) + 1'b1) : $unsigned(in_z);

  // largest axis, ties to the earlier one; zero counts as positive
  always_comb begin
    best     = 2'd0;
    best_neg = in_x[SAMPLE_WIDTH-1];
    if (ay > ax) begin
      best     = 2'd1;
      best_neg = in_y[SAMPLE_WIDTH-1];
    end
    if (az > ((best == 2'd1) ? ay : ax)) begin
      best     = 2'd2;
      best_neg = in_z[SAMPLE_WIDTH-1];
    end
    cur_axis = {best, ~best_neg};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid   <= 1'b0;
      meas_valid <= 1'b0;
    end else begin
      sq_valid   <= in_valid;
      meas_valid <= sq_valid;
    end
  end

  // payload: squares, then their sum
  always_ff @(posedge clk) begin
    sq_x      <= ax * ax;
    sq_y      <= ay * ay;
    sq_z      <= az * az;
    s2_x      <= in_x;
    s2_y      <= in_y;
    s2_z      <= in_z;
    s2_axis   <= cur_axis;
    meas.mag  <= sq_x + sq_y + sq_z;
    meas.x    <= s2_x;
    meas.y    <= s2_y;
    meas.z    <= s2_z;
    meas.axis <= s2_axis;
  end

  assign stage_valid = {meas_valid, sq_valid};

endmodule

@@ rtl/omed_decide.sv @@
// Detector state: motion check timing, stop delay and up axis debounce.
// Turns one measured sample into up to two events. Depends on omed_pkg.
module omed_decide (
  input  logic            clk,
  input  logic            rst,
  input  omed_pkg::cfg_t  cfg,
  input  logic            meas_valid,
  input  omed_pkg::meas_t meas,
  output logic [1:0]      ev_cnt,
  output omed_pkg::evt_t  ev0,
  output omed_pkg::evt_t  ev1
);
  import omed_pkg::*;

  logic [7:0]  check_phase, check_phase_next;
  logic [16:0] stable_count, stable_count_next;
  logic [15:0] ticks_since_move, ticks_since_move_next;
  logic        moving_flag, moving_flag_next;
  axis_t       reported_axis, reported_axis_next;
  axis_t       candidate_axis, candidate_axis_next;

  logic [DEV_W-1:0] mag_w, grav_w, dev;
  logic             over_tol;
  logic [7:0]       phase_inc;
  logic [15:0]      tsm_inc;
  logic [16:0]      stable_inc;
  evt_t             ev;
  logic [1:0]       cnt;
  evt_t             e0, e1;

  function automatic evt_t make_event(input ev_kind_t kind, input axis_t axis,
                                      input logic carry, input meas_t m);
    evt_t r;
    r.kind = kind;
    r.axis = axis;
    r.x    = carry ? m.x : '0;
    r.y    = carry ? m.y : '0;
    r.z    = carry ? m.z : '0;
    r.last = 1'b0;
    return r;
  endfunction

  // deviation of squared magnitude from gravity
  assign mag_w    = DEV_W'(meas.mag);
  assign grav_w   = DEV_W'(cfg.gravity_sq);
  assign dev      = (mag_w > grav_w) ? (mag_w - grav_w) : (grav_w - mag_w);
  assign over_tol = dev > DEV_W'(cfg.moving_tolerance);

  assign phase_inc  = check_phase + 8'd1;
  assign tsm_inc    = (ticks_since_move != 16'hFFFF) ? (ticks_since_move + 16'd1)
                                                     : ticks_since_move;
  assign stable_inc = (stable_count != '1) ? (stable_count + 17'd1) : stable_count;

  // event generation and next state
  always_comb begin
    check_phase_next      = check_phase;
    stable_count_next     = stable_count;
    ticks_since_move_next = ticks_since_move;
    moving_flag_next      = moving_flag;
    reported_axis_next    = reported_axis;
    candidate_axis_next   = candidate_axis;
    cnt = 2'd0;
    e0  = '0;
    e1  = '0;
    ev  = '0;
    if (meas_valid) begin
      ticks_since_move_next = tsm_inc;
      check_phase_next      = phase_inc;
      // periodic motion check
      if (phase_inc == cfg.check_period) begin
        check_phase_next = '0;
        if (over_tol) begin
          e0 = make_event(EV_MOVED, reported_axis, 1'b1, meas);
          cnt = 2'd1;
          ticks_since_move_next = '0;
          moving_flag_next      = 1'b1;
        end else if (moving_flag && (tsm_inc > cfg.stop_delay_ticks)) begin
          if (reported_axis != candidate_axis) begin
            reported_axis_next = candidate_axis;
            e0  = make_event(EV_CHANGED, candidate_axis, 1'b0, meas);
            cnt = 2'd1;
          end
          ev = make_event(EV_STOPPED, reported_axis_next, 1'b0, meas);
          if (cnt == 2'd0) begin
            e0 = ev;
          end else begin
            e1 = ev;
          end
          cnt = cnt + 2'd1;
          moving_flag_next = 1'b0;
        end
      end
      // up axis debounce
      if (meas.axis == candidate_axis) begin
        if (candidate_axis != reported_axis_next) begin
          stable_count_next = stable_inc;
          if ((stable_inc > {1'b0, cfg.stable_ticks}) && (cnt != 2'd2)) begin
            reported_axis_next = candidate_axis;
            ev = make_event(EV_CHANGED, candidate_axis, 1'b0, meas);
            if (cnt == 2'd0) begin
              e0 = ev;
            end else begin
              e1 = ev;
            end
            cnt = cnt + 2'd1;
          end
        end else begin
          stable_count_next = '0;
        end
      end else begin
        stable_count_next   = '0;
        candidate_axis_next = meas.axis;
      end
      // mark the final item of this sample
      if (cnt == 2'd1) begin
        e0.last = 1'b1;
      end else if (cnt == 2'd2) begin
        e1.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_phase      <= '0;
      stable_count     <= '0;
      ticks_since_move <= '0;
      moving_flag      <= 1'b0;
      reported_axis    <= AXIS_UNKNOWN;
      candidate_axis   <= AXIS_UNKNOWN;
    end else begin
      check_phase      <= check_phase_next;
      stable_count     <= stable_count_next;
      ticks_since_move <= ticks_since_move_next;
      moving_flag      <= moving_flag_next;
      reported_axis    <= reported_axis_next;
      candidate_axis   <= candidate_axis_next;
    end
  end

  assign ev_cnt = cnt;
  assign ev0    = e0;
  assign ev1    = e1;

  // two events come only as moved+changed or changed+stopped
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> (e0.kind == EV_MOVED && e1.kind == EV_CHANGED) ||
                    (e0.kind == EV_CHANGED && e1.kind == EV_STOPPED))
    else $error("bad event pair");

  // last flag only on the final event of a sample
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> e1.last && !e0.last)
    else $error("last flag misplaced");

  // a moved event leaves the block moving
  a_moved_sets: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd0 && e0.kind == EV_MOVED |=> moving_flag)
    else $error("moving flag not set after moved");

  // a stopped event that follows a changed event leaves the block at rest
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 && e1.kind == EV_STOPPED |=> !moving_flag)
    else $error("moving flag not cleared after stopped");

endmodule

@@ rtl/omed_evq.sv @@
// Event queue: takes up to two items per cycle, hands out one per cycle while rd_ready is high.
// Depends on omed_pkg.
module omed_evq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    wr_cnt,
  input  omed_pkg::evt_t                wr0,
  input  omed_pkg::evt_t                wr1,
  output logic                          rd_valid,
  input  logic                          rd_ready,
  output omed_pkg::evt_t                rd_data,
  output logic [omed_pkg::EVQ_CW-1:0]   count
);
  import omed_pkg::*;

  evt_t              mem [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_ptr, rd_ptr;
  logic              pop;

  assign rd_valid = (count != '0);
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + EVQ_AW'(wr_cnt);
      rd_ptr <= rd_ptr + EVQ_AW'(pop);
      count  <= count + EVQ_CW'(wr_cnt) - EVQ_CW'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[wr_ptr] <= wr0;
    end
    if (wr_cnt == 2'd2) begin
      mem[wr_ptr + EVQ_AW'(1)] <= wr1;
    end
  end

endmodule

@@ rtl/orientation_motion_event_detect_core.sv @@
// Orientation and motion event detector, top level.
// Accepted items pass the input register, square and sum registers and the
// event queue. One item per cycle; up to two events per item leave at one per
// cycle while m_axis_tready is high; 8-entry queue room gates s_axis_tready.
// Reset (rst, synchronous): clears detector state, empties the queue and
// restores every configuration register to its default. Uses omed_pkg.
module orientation_motion_event_detect_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // accel_x, accel_y, accel_z
  input  logic [omed_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // up_axis, moved_x, moved_y, moved_z
  output logic [omed_pkg::OUT_W-1:0]    m_axis_tdata,
  // event_kind
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_wr_en,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import omed_pkg::*;

  cfg_t             cfg;
  logic             in_valid;
  sample_t          in_x, in_y, in_z;
  logic [1:0]       stage_valid;
  logic             meas_valid;
  meas_t            meas;
  logic [1:0]       ev_cnt;
  evt_t             ev0, ev1, rd_data;
  logic [EVQ_CW-1:0] q_count;
  logic [EVQ_CW-1:0] q_free;
  logic [1:0]       inflight;
  logic [EVQ_CW-1:0] need;
  logic             accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity_sq       <= 32'd1048576;
      cfg.moving_tolerance <= 32'd10896;
      cfg.check_period     <= 8'd10;
      cfg.stable_ticks     <= 16'd52;
      cfg.stop_delay_ticks <= 16'd50;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRAVITY_SQ:   cfg.gravity_sq       <= cfg_data;
        CFG_MOVING_TOL:   cfg.moving_tolerance <= cfg_data;
        CFG_CHECK_PERIOD: cfg.check_period     <= cfg_data[7:0];
        CFG_STABLE_TICKS: cfg.stable_ticks     <= cfg_data[15:0];
        CFG_STOP_DELAY:   cfg.stop_delay_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // admit an item only if the queue can take two events for it and for
  // every item still in the pipeline
  assign inflight      = 2'(in_valid) + 2'(stage_valid[0]) + 2'(stage_valid[1]);
  assign need          = EVQ_CW'({inflight, 1'b0}) + EVQ_CW'(2);
  assign q_free        = EVQ_CW'(EVQ_DEPTH) - q_count;
  assign s_axis_tready = (q_free >= need);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_x <= sample_t'(s_axis_tdata[SAMPLE_WIDTH-1:0]);
      in_y <= sample_t'(s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
      in_z <= sample_t'(s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]);
    end
  end

  omed_square u_square (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_z        (in_z),
    .stage_valid (stage_valid),
    .meas_valid  (meas_valid),
    .meas        (meas)
  );

  omed_decide u_decide (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .meas_valid (meas_valid),
    .meas       (meas),
    .ev_cnt     (ev_cnt),
    .ev0        (ev0),
    .ev1        (ev1)
  );

  omed_evq u_evq (
    .clk      (clk),
    .rst      (rst),
    .wr_cnt   (ev_cnt),
    .wr0      (ev0),
    .wr1      (ev1),
    .rd_valid (m_axis_tvalid),
    .rd_ready (m_axis_tready),
    .rd_data  (rd_data),
    .count    (q_count)
  );

  // output packing
  assign m_axis_tdata = OUT_W'({rd_data.z, rd_data.y, rd_data.x, rd_data.axis});
  assign m_axis_tuser = rd_data.kind;
  assign m_axis_tlast = rd_data.last;

endmodule

@@ sim/tb_orientation_motion_event_detect_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for orientation_motion_event_detect_core.
// Drives accelerometer items, predicts the up-axis, moved and stopped events
// with an in-bench detector model and checks every event; uses omed_pkg.
module tb_orientation_motion_event_detect_core;
  import omed_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } accel_t;

  logic                clk;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_wr_en     = 1'b0;
  logic [2:0]          cfg_index     = '0;
  logic [31:0]         cfg_data      = '0;

  orientation_motion_event_detect_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Items waiting to be offered, events waiting to arrive
  accel_t sample_queue [$];
  evt_t   axis_events [$];

  // Detector model state and registers
  cfg_t        det_cfg;
  logic [7:0]  chk_phase;
  logic [16:0] stable_cnt;
  logic [15:0] since_move;
  logic        moving;
  axis_t       rep_axis;
  axis_t       cand_axis;

  int  mismatches  = 0;
  int  idle_cycles = 0;
  bit  tx_idle_on  = 1'b1;
  bit  rx_idle_on  = 1'b1;
  bit  rx_hold_req = 1'b0;
  int  tx_gap      = 0;
  int  rx_wait     = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  task automatic model_reset();
    det_cfg.gravity_sq       = 32'd1048576;
    det_cfg.moving_tolerance = 32'd10896;
    det_cfg.check_period     = 8'd10;
    det_cfg.stable_ticks     = 16'd52;
    det_cfg.stop_delay_ticks = 16'd50;
    chk_phase  = '0;
    stable_cnt = '0;
    since_move = '0;
    moving     = 1'b0;
    rep_axis   = AXIS_UNKNOWN;
    cand_axis  = AXIS_UNKNOWN;
  endtask

  function automatic evt_t make_event(ev_kind_t k, axis_t a, accel_t s, logic carry);
    evt_t e;
    e.kind = k;
    e.axis = a;
    e.x    = carry ? s.x : '0;
    e.y    = carry ? s.y : '0;
    e.z    = carry ? s.z : '0;
    e.last = 1'b0;
    return e;
  endfunction

  // One tick of the detector: update state, queue the events it causes
  task automatic detect_tick(input accel_t s);
    int     comp [3];
    int     am [3];
    longint mag_sq;
    longint grav;
    longint tol;
    longint dev;
    int     best;
    int     i;
    axis_t  cur;
    evt_t   made [$];
    comp[0] = s.x;
    comp[1] = s.y;
    comp[2] = s.z;
    mag_sq  = 0;
    for (i = 0; i < 3; i++) begin
      am[i]  = (comp[i] < 0) ? -comp[i] : comp[i];
      mag_sq += longint'(am[i]) * longint'(am[i]);
    end
    grav = det_cfg.gravity_sq;
    tol  = det_cfg.moving_tolerance;

    if (since_move != 16'hFFFF) since_move = since_move + 16'd1;

    // motion check once per period
    chk_phase = chk_phase + 8'd1;
    if (chk_phase == det_cfg.check_period) begin
      chk_phase = '0;
      dev = (mag_sq > grav) ? mag_sq - grav : grav - mag_sq;
      if (dev > tol) begin
        made.push_back(make_event(EV_MOVED, rep_axis, s, 1'b1));
        since_move = '0;
        moving     = 1'b1;
      end else if (moving && since_move > det_cfg.stop_delay_ticks) begin
        if (rep_axis != cand_axis) begin
          rep_axis = cand_axis;
          made.push_back(make_event(EV_CHANGED, cand_axis, s, 1'b0));
        end
        made.push_back(make_event(EV_STOPPED, rep_axis, s, 1'b0));
        moving = 1'b0;
      end
    end

    // up axis: largest magnitude, earlier axis wins ties, zero is positive
    best = 0;
    for (i = 1; i < 3; i++)
      if (am[i] > am[best]) best = i;
    cur = axis_t'(best * 2 + ((comp[best] < 0) ? 0 : 1));

    if (cur == cand_axis) begin
      if (cand_axis != rep_axis) begin
        if (stable_cnt != 17'h1FFFF) stable_cnt = stable_cnt + 17'd1;
        if (stable_cnt > det_cfg.stable_ticks && made.size() < 2) begin
          rep_axis = cand_axis;
          made.push_back(make_event(EV_CHANGED, cand_axis, s, 1'b0));
        end
      end else begin
        stable_cnt = '0;
      end
    end else begin
      stable_cnt = '0;
      cand_axis  = cur;
    end

    if (made.size() > 0) made[made.size() - 1].last = 1'b1;
    foreach (made[k]) axis_events.push_back(made[k]);
  endtask

  // ------------------------------------------------------------ stimulus

  function automatic accel_t mk(int x, int y, int z);
    accel_t s;
    s.x = sample_t'(x);
    s.y = sample_t'(y);
    s.z = sample_t'(z);
    return s;
  endfunction

  // At rest, 1 g along the given axis code, a little noise elsewhere
  function automatic accel_t rest_sample(int code);
    int c [3];
    int main_mag;
    int i;
    main_mag = 1020 + int'($urandom_range(0, 8));
    for (i = 0; i < 3; i++) c[i] = int'($urandom_range(0, 20)) - 10;
    c[code / 2] = (code % 2) ? main_mag : -main_mag;
    return mk(c[0], c[1], c[2]);
  endfunction

  function automatic accel_t shaken_sample(int code);
    accel_t r;
    r = rest_sample(code);
    return mk(int'(r.x) + int'($urandom_range(0, 1200)) - 600,
              int'(r.y) + int'($urandom_range(0, 1200)) - 600,
              int'(r.z) + int'($urandom_range(0, 1200)) - 600);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_GRAVITY_SQ:   det_cfg.gravity_sq       = val;
      CFG_MOVING_TOL:   det_cfg.moving_tolerance = val;
      CFG_CHECK_PERIOD: det_cfg.check_period     = val[7:0];
      CFG_STABLE_TICKS: det_cfg.stable_ticks     = val[15:0];
      CFG_STOP_DELAY:   det_cfg.stop_delay_ticks = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] grav, logic [31:0] tol, logic [7:0] period,
                            logic [15:0] stable, logic [15:0] stop_delay);
    write_reg(CFG_GRAVITY_SQ, grav);
    write_reg(CFG_MOVING_TOL, tol);
    write_reg(CFG_CHECK_PERIOD, {24'd0, period});
    write_reg(CFG_STABLE_TICKS, {16'd0, stable});
    write_reg(CFG_STOP_DELAY, {16'd0, stop_delay});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every item is in and every event is out, then let the pipe settle;
  // look again afterwards in case the last item was only just being offered
  task automatic drain();
    do begin
      while (sample_queue.size() != 0 || s_axis_tvalid || axis_events.size() != 0)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (sample_queue.size() != 0 || s_axis_tvalid || axis_events.size() != 0);
  endtask

  // Runs of one orientation, often opened by a shaking burst, some wild items
  task automatic run_phase(int n_items, int run_max, bit tx_idle, bit rx_idle, bit hold);
    int     made_n;
    int     code;
    int     run;
    int     burst;
    int     i;
    int     pick;
    accel_t s;
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    made_n     = 0;
    while (made_n < n_items) begin
      code  = $urandom_range(0, 5);
      run   = $urandom_range(1, run_max);
      burst = $urandom_range(0, 1) ? $urandom_range(1, 15) : 0;
      for (i = 0; i < run && made_n < n_items; i++) begin
        pick = $urandom_range(0, 99);
        if (i < burst) s = shaken_sample(code);
        else if (pick < 6) s = mk($urandom, $urandom, $urandom);
        else s = rest_sample(code);
        sample_queue.push_back(s);
        made_n++;
      end
    end
    if (hold) rx_hold_req = 1'b1;
    drain();
  endtask

  // -------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        accel_t s;
        s = sample_queue.pop_front();
        s_axis_tdata  <= {s.z, s.y, s.x};
        s_axis_tvalid <= 1'b1;
        tx_gap = tx_idle_on ? pick_gap() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_wait     = HOLD_CYCLES;
      end else if (rx_wait == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
        rx_wait = pick_gap();
      end
      if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        detect_tick(mk($signed(s_axis_tdata[15:0]), $signed(s_axis_tdata[31:16]),
                       $signed(s_axis_tdata[47:32])));

      if (m_axis_tvalid && m_axis_tready) begin
        if (axis_events.size() == 0) begin
          $error("unexpected event: event_kind %0d up_axis %0d", m_axis_tuser,
                 m_axis_tdata[2:0]);
          mismatches++;
        end else begin
          evt_t e;
          e = axis_events.pop_front();
          if (m_axis_tuser !== e.kind) begin
            $error("event_kind: expected %0d, got %0d", e.kind, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[2:0] !== e.axis) begin
            $error("up_axis: expected %0d, got %0d", e.axis, m_axis_tdata[2:0]);
            mismatches++;
          end
          if (m_axis_tdata[18:3] !== e.x) begin
            $error("moved_x: expected %0d, got %0d", e.x, $signed(m_axis_tdata[18:3]));
            mismatches++;
          end
          if (m_axis_tdata[34:19] !== e.y) begin
            $error("moved_y: expected %0d, got %0d", e.y, $signed(m_axis_tdata[34:19]));
            mismatches++;
          end
          if (m_axis_tdata[50:35] !== e.z) begin
            $error("moved_z: expected %0d, got %0d", e.z, $signed(m_axis_tdata[50:35]));
            mismatches++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
            mismatches++;
          end
        end
      end

      // watchdog on cycles with no progress at all
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------ sequence

  initial begin
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: check every tick, short stability and stop delay
    set_config(32'd1048576, 32'd10896, 8'd1, 16'd1, 16'd2);
    sample_queue.push_back(mk(0, 0, 0));
    sample_queue.push_back(mk(32767, 32767, 32767));
    sample_queue.push_back(mk(-32768, -32768, -32768));
    sample_queue.push_back(mk(-32768, 0, 0));
    sample_queue.push_back(mk(0, -32768, 0));
    sample_queue.push_back(mk(0, 0, -32768));
    sample_queue.push_back(mk(0, 0, 32767));
    sample_queue.push_back(mk(-600, 600, 600));   // tie, x wins
    sample_queue.push_back(mk(100, -700, 700));   // tie, y wins
    for (int i = 0; i < 6; i++) sample_queue.push_back(rest_sample(5));
    for (int i = 0; i < 6; i++) sample_queue.push_back(rest_sample(0));
    for (int i = 0; i < 4; i++) sample_queue.push_back(rest_sample(3));
    drain();

    // random phases over a spread of register settings
    set_config(32'd1048576, 32'd10896, 8'd10, 16'd52, 16'd50);
    run_phase(450, 75, 1'b1, 1'b1, 1'b0);

    set_config(32'd1048576, 32'd20000, 8'd1, 16'd0, 16'd0);
    run_phase(250, 20, 1'b0, 1'b0, 1'b0);

    set_config(32'd0, 32'd0, 8'd255, 16'd65535, 16'd65535);
    run_phase(150, 100, 1'b1, 1'b1, 1'b0);

    // period zero means a check every 256 ticks
    set_config(32'd3221225472, 32'hFFFF_FFFF, 8'd0, 16'd3, 16'd1);
    run_phase(300, 30, 1'b1, 1'b1, 1'b0);

    // every tick is checked against zero tolerance; long receiver hold backs the block up
    set_config(32'd1048576, 32'd0, 8'd1, 16'd0, 16'd0);
    run_phase(200, 20, 1'b0, 1'b1, 1'b1);

    set_config(32'd3221225472, 32'd2000000000, 8'd2, 16'd20, 16'd5);
    run_phase(200, 40, 1'b1, 1'b1, 1'b0);

    set_config(32'd1048576, 32'd10896, 8'd3, 16'd8, 16'd12);
    run_phase(300, 40, 1'b1, 1'b1, 1'b0);

    if (mismatches == 0 && axis_events.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
